// ===== hw/rtl/sen_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sen_pkg
// Shared widths, register indexes and stage types of the Sobel edge block.
// ----------------------------------------------------------------------------
package sen_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 5;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 20;
    localparam int MAG_W      = 21;
    localparam int THR_W      = 11;
    localparam int THR_SQ_W   = 2 * THR_W;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPRESS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd4;

    typedef struct packed {
        logic [THR_SQ_W-1:0] lo_sq;
        logic [THR_SQ_W-1:0] hi_sq;
        logic [THR_SQ_W-1:0] sup_sq;
        logic [WID_W-1:0]    width;
        logic [HGT_W-1:0]    height;
    } t_cfg;

    typedef struct packed {
        logic calc;
        logic emit_up;
        logic thin_ok;
        logic emit_last;
        logic par;
    } t_flags;

    typedef struct packed {
        t_flags           flags;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_item;

    typedef struct packed {
        t_item                    item;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
    } t_grad;

    typedef struct packed {
        logic             emit_up;
        logic             emit_last;
        logic [ROW_W-1:0] row_up;
        logic [ROW_W-1:0] row_last;
        logic [COL_W-1:0] col;
        logic             band_up;
        logic             thin_up;
        logic             band_last;
    } t_res;

endpackage
`default_nettype wire

// ===== hw/rtl/sen_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sen_cfg
// Configuration registers, frame size clamping and squared thresholds.
// ----------------------------------------------------------------------------
module sen_cfg import sen_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    logic [THR_W-1:0]    r_lo;
    logic [THR_W-1:0]    r_hi;
    logic [THR_W-1:0]    r_sup;
    logic [WID_W-1:0]    r_width;
    logic [HGT_W-1:0]    r_height;
    logic [THR_SQ_W-1:0] r_lo_sq;
    logic [THR_SQ_W-1:0] r_hi_sq;
    logic [THR_SQ_W-1:0] r_sup_sq;
    logic [WID_W-1:0]    width_eff;
    logic [HGT_W-1:0]    height_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo     <= THR_W'(50);
            r_hi     <= THR_W'(200);
            r_sup    <= THR_W'(50);
            r_width  <= WID_W'(1024);
            r_height <= HGT_W'(480);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BAND_LOW:  r_lo     <= i_cfg_data[THR_W-1:0];
                REG_BAND_HIGH: r_hi     <= i_cfg_data[THR_W-1:0];
                REG_SUPPRESS:  r_sup    <= i_cfg_data[THR_W-1:0];
                REG_WIDTH:     r_width  <= i_cfg_data[WID_W-1:0];
                REG_HEIGHT:    r_height <= i_cfg_data[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_sq  <= THR_SQ_W'(2500);
            r_hi_sq  <= THR_SQ_W'(40000);
            r_sup_sq <= THR_SQ_W'(2500);
        end else begin
            r_lo_sq  <= THR_SQ_W'(r_lo) * THR_SQ_W'(r_lo);
            r_hi_sq  <= THR_SQ_W'(r_hi) * THR_SQ_W'(r_hi);
            r_sup_sq <= THR_SQ_W'(r_sup) * THR_SQ_W'(r_sup);
        end
    end

    always_comb begin
        width_eff = r_width;
        if (int'(r_width) < MIN_SIZE) begin
            width_eff = WID_W'(MIN_SIZE);
        end else if (int'(r_width) > MAX_WIDTH) begin
            width_eff = WID_W'(MAX_WIDTH);
        end
        height_eff = r_height;
        if (int'(r_height) < MIN_SIZE) begin
            height_eff = HGT_W'(MIN_SIZE);
        end else if (int'(r_height) > MAX_HEIGHT) begin
            height_eff = HGT_W'(MAX_HEIGHT);
        end
    end

    assign o_cfg.lo_sq  = r_lo_sq;
    assign o_cfg.hi_sq  = r_hi_sq;
    assign o_cfg.sup_sq = r_sup_sq;
    assign o_cfg.width  = width_eff;
    assign o_cfg.height = height_eff;

endmodule
`default_nettype wire

// ===== hw/rtl/sen_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sen_front
// Raster counters, pixel line store, 3x3 window and Sobel X and Y sums.
// ----------------------------------------------------------------------------
module sen_front import sen_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [PIX_W-1:0] i_pixel,
    output logic                  o_stall,
    input  t_cfg                  i_cfg,
    output logic                  o_valid,
    output t_grad                 o_item,
    input  wire logic             i_stall
);

    logic [2*PIX_W-1:0] pix_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_pix_rd;
    logic [PIX_W-1:0]   r_win [9];

    logic               r_clr_busy;
    logic [COL_W-1:0]   r_clr_addr;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   n_row;
    logic [COL_W-1:0]   n_col;
    logic [ROW_W-1:0]   cur_row;
    logic [COL_W-1:0]   cur_col;
    t_flags             cur_flags;

    logic               r_v1;
    t_item              r_s1_item;
    logic [PIX_W-1:0]   r_s1_px;
    logic               r_v2;
    t_item              r_s2_item;

    logic               accept;
    logic               mv1;
    logic               mv2;
    logic               pix_we;
    logic [COL_W-1:0]   pix_wa;
    logic [2*PIX_W-1:0] pix_wd;
    logic [PIX_W-1:0]   top_px;
    logic [PIX_W-1:0]   mid_px;
    logic [PIX_W+1:0]   gx_pos;
    logic [PIX_W+1:0]   gx_neg;
    logic [PIX_W+1:0]   gy_pos;
    logic [PIX_W+1:0]   gy_neg;

    assign mv2     = r_v2 && !i_stall;
    assign mv1     = r_v1 && (!r_v2 || mv2);
    assign o_stall = r_clr_busy || (r_v1 && !mv1);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        cur_col = r_col;
        cur_row = r_row;
        if (int'(r_col) >= int'(i_cfg.width)) begin
            cur_col = '0;
            if (int'(r_row) + 1 >= int'(i_cfg.height)) begin
                cur_row = '0;
            end else begin
                cur_row = r_row + 1'b1;
            end
        end else if (int'(r_row) >= int'(i_cfg.height)) begin
            cur_row = '0;
        end

        n_col = cur_col + 1'b1;
        n_row = cur_row;
        if (int'(cur_col) + 1 >= int'(i_cfg.width)) begin
            n_col = '0;
            if (int'(cur_row) + 1 >= int'(i_cfg.height)) begin
                n_row = '0;
            end else begin
                n_row = cur_row + 1'b1;
            end
        end

        cur_flags.calc      = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
        cur_flags.emit_up   = cur_row >= ROW_W'(3);
        cur_flags.thin_ok   = (cur_row >= ROW_W'(4)) && (cur_col >= COL_W'(3))
                              && (int'(cur_col) + 2 <= int'(i_cfg.width));
        cur_flags.emit_last = int'(cur_row) + 1 == int'(i_cfg.height);
        cur_flags.par       = cur_row[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (mv1) begin
                r_v1 <= 1'b0;
            end
            if (mv1) begin
                r_v2 <= 1'b1;
            end else if (mv2) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item.flags <= cur_flags;
            r_s1_item.row   <= cur_row;
            r_s1_item.col   <= cur_col;
            r_s1_px         <= i_pixel;
        end
        if (mv1) begin
            r_s2_item <= r_s1_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pix_rd <= pix_mem[cur_col];
        end
        if (pix_we) begin
            pix_mem[pix_wa] <= pix_wd;
        end
    end

    assign top_px = r_s1_item.flags.par ? r_pix_rd[2*PIX_W-1:PIX_W] : r_pix_rd[PIX_W-1:0];
    assign mid_px = r_s1_item.flags.par ? r_pix_rd[PIX_W-1:0] : r_pix_rd[2*PIX_W-1:PIX_W];

    always_comb begin
        pix_we = r_clr_busy || mv1;
        pix_wa = r_clr_busy ? r_clr_addr : r_s1_item.col;
        if (r_clr_busy) begin
            pix_wd = '0;
        end else if (r_s1_item.flags.par) begin
            pix_wd = {r_s1_px, r_pix_rd[PIX_W-1:0]};
        end else begin
            pix_wd = {r_pix_rd[2*PIX_W-1:PIX_W], r_s1_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (mv1) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= top_px;
            r_win[3] <= r_win[4];
            r_win[4] <= r_win[5];
            r_win[5] <= mid_px;
            r_win[6] <= r_win[7];
            r_win[7] <= r_win[8];
            r_win[8] <= r_s1_px;
        end
    end

    assign gx_pos = (PIX_W+2)'(r_win[0]) + {1'b0, r_win[3], 1'b0} + (PIX_W+2)'(r_win[6]);
    assign gx_neg = (PIX_W+2)'(r_win[2]) + {1'b0, r_win[5], 1'b0} + (PIX_W+2)'(r_win[8]);
    assign gy_pos = (PIX_W+2)'(r_win[0]) + {1'b0, r_win[1], 1'b0} + (PIX_W+2)'(r_win[2]);
    assign gy_neg = (PIX_W+2)'(r_win[6]) + {1'b0, r_win[7], 1'b0} + (PIX_W+2)'(r_win[8]);

    assign o_valid     = r_v2;
    assign o_item.item = r_s2_item;
    assign o_item.gx   = signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
    assign o_item.gy   = signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});

`ifndef SYNTHESIS
    a_no_item_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_v1)
        else $error("pixel item present during line store clearing");

    a_clear_covers_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(r_clr_addr) == COL_W'(MAX_WIDTH - 1))
        else $error("line store clearing ended early");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/sen_nms.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sen_nms
// Squared magnitude, magnitude line store and non-maximum suppression.
// ----------------------------------------------------------------------------
module sen_nms import sen_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  t_grad     i_item,
    output logic      o_stall,
    input  t_cfg      i_cfg,
    output logic      o_valid,
    output t_res      o_res,
    input  wire logic i_stall
);

    logic [2*MAG_W-1:0] mag_mem [MAX_WIDTH];
    logic [2*MAG_W-1:0] r_mag_rd;
    logic [2*MAG_W-1:0] r_prev1;
    logic [2*MAG_W-1:0] r_prev2;

    logic                     r_v3;
    t_item                    r_s3_item;
    logic signed [GRAD_W-1:0] r_s3_gx;
    logic signed [GRAD_W-1:0] r_s3_gy;

    logic               r_v4;
    t_item              r_s4_item;
    logic [SQ_W-1:0]    r_sqx;
    logic [SQ_W-1:0]    r_sqy;
    logic [2*MAG_W-1:0] r_rt_e;
    logic [2*MAG_W-1:0] r_mc_e;
    logic [2*MAG_W-1:0] r_lf_e;

    logic             r_v5;
    t_item            r_s5_item;
    logic [MAG_W-1:0] r_m;
    logic [MAG_W-1:0] r_mc;
    logic             r_gt_lf;
    logic             r_gt_rt;
    logic             r_gt_up;
    logic             r_gt_s;
    logic             r_band_mc;

    logic                       acc;
    logic                       mv3;
    logic                       mv4;
    logic                       mv5;
    logic signed [2*GRAD_W-1:0] sqx_full;
    logic signed [2*GRAD_W-1:0] sqy_full;
    logic [MAG_W-1:0]           m4;
    logic [MAG_W-1:0]           mc4;
    logic [MAG_W-1:0]           up4;
    logic [MAG_W-1:0]           lf4;
    logic [MAG_W-1:0]           rt4;
    logic                       gt_m;
    logic                       band_m;
    logic                       mag_we;
    logic [COL_W-1:0]           mag_wa;
    logic [2*MAG_W-1:0]         mag_wd;

    assign mv5     = r_v5 && !i_stall;
    assign mv4     = r_v4 && (!r_v5 || mv5);
    assign mv3     = r_v3 && (!r_v4 || mv4);
    assign o_stall = r_v3 && !mv3;
    assign acc     = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (acc) begin
                r_v3 <= 1'b1;
            end else if (mv3) begin
                r_v3 <= 1'b0;
            end
            if (mv3) begin
                r_v4 <= 1'b1;
            end else if (mv4) begin
                r_v4 <= 1'b0;
            end
            if (mv4) begin
                r_v5 <= 1'b1;
            end else if (mv5) begin
                r_v5 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_mag_rd <= mag_mem[i_item.item.col - COL_W'(1)];
        end
        if (mag_we) begin
            mag_mem[mag_wa] <= mag_wd;
        end
    end

    assign sqx_full = r_s3_gx * r_s3_gx;
    assign sqy_full = r_s3_gy * r_s3_gy;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s3_item <= i_item.item;
            r_s3_gx   <= i_item.gx;
            r_s3_gy   <= i_item.gy;
        end
        if (mv3) begin
            r_s4_item <= r_s3_item;
            r_sqx     <= sqx_full[SQ_W-1:0];
            r_sqy     <= sqy_full[SQ_W-1:0];
            r_rt_e    <= r_mag_rd;
            r_mc_e    <= r_prev1;
            r_lf_e    <= r_prev2;
            r_prev1   <= r_mag_rd;
            r_prev2   <= r_prev1;
        end
    end

    always_comb begin
        m4 = MAG_W'(r_sqx) + MAG_W'(r_sqy);
        if (r_s4_item.flags.par) begin
            mc4 = r_mc_e[MAG_W-1:0];
            up4 = r_mc_e[2*MAG_W-1:MAG_W];
            lf4 = r_lf_e[MAG_W-1:0];
            rt4 = r_rt_e[MAG_W-1:0];
        end else begin
            mc4 = r_mc_e[2*MAG_W-1:MAG_W];
            up4 = r_mc_e[MAG_W-1:0];
            lf4 = r_lf_e[2*MAG_W-1:MAG_W];
            rt4 = r_rt_e[2*MAG_W-1:MAG_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv4) begin
            r_s5_item <= r_s4_item;
            r_m       <= m4;
            r_mc      <= mc4;
            r_gt_lf   <= mc4 > lf4;
            r_gt_rt   <= mc4 > rt4;
            r_gt_up   <= mc4 > up4;
            r_gt_s    <= THR_SQ_W'(mc4) > i_cfg.sup_sq;
            r_band_mc <= (THR_SQ_W'(mc4) > i_cfg.lo_sq) && (THR_SQ_W'(mc4) < i_cfg.hi_sq);
        end
    end

    assign gt_m   = r_mc > r_m;
    assign band_m = (THR_SQ_W'(r_m) > i_cfg.lo_sq) && (THR_SQ_W'(r_m) < i_cfg.hi_sq);

    assign mag_we = mv5 && r_s5_item.flags.calc;
    assign mag_wa = r_s5_item.col - COL_W'(2);
    assign mag_wd = r_s5_item.flags.par ? {r_m, r_mc} : {r_mc, r_m};

    assign o_valid          = r_v5;
    assign o_res.emit_up    = r_s5_item.flags.calc && r_s5_item.flags.emit_up;
    assign o_res.emit_last  = r_s5_item.flags.calc && r_s5_item.flags.emit_last;
    assign o_res.row_up     = r_s5_item.row - ROW_W'(3);
    assign o_res.row_last   = r_s5_item.row - ROW_W'(2);
    assign o_res.col        = r_s5_item.col - COL_W'(2);
    assign o_res.band_up    = r_band_mc;
    assign o_res.thin_up    = r_s5_item.flags.thin_ok && r_gt_s
                              && ((r_gt_lf && r_gt_rt) || (r_gt_up && gt_m));
    assign o_res.band_last  = band_m;

endmodule
`default_nettype wire

// ===== hw/rtl/sobel_edge_with_nms.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_with_nms
// Sobel 3x3 edge detector with band thresholds and non-maximum suppression.
// ----------------------------------------------------------------------------
// The block takes one gray pixel per clock in raster order while o_stall is
// low and returns one item per interior position, tagged with its grid row
// and column. A pixel of the last frame row returns two items, which leave
// one after the other; every other pixel returns at most one, so elsewhere
// the sustained rate is one pixel per clock without output stall, set by the
// single read and write port of each line store. Items pass stages s1 to s5
// and the output register. After reset the input stall is high while the
// pixel line store is cleared one entry per cycle. The user must write
// configuration only while the block is idle; the block does not enforce it.
module sobel_edge_with_nms import sen_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [PIX_W-1:0]      i_pixel,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [ROW_W-1:0]           o_grid_row,
    output logic [COL_W-1:0]           o_grid_col,
    output logic                       o_band_edge,
    output logic                       o_thin_edge,
    output logic                       o_last_of_run,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_grad grad;
    t_res  res;
    logic  grad_valid;
    logic  grad_stall;
    logic  res_valid;

    logic             r_o_valid;
    logic [ROW_W-1:0] r_o_row;
    logic [COL_W-1:0] r_o_col;
    logic             r_o_band;
    logic             r_o_thin;
    logic             r_o_last;
    logic             r_p_valid;
    logic [ROW_W-1:0] r_p_row;
    logic [COL_W-1:0] r_p_col;
    logic             r_p_band;

    logic take;
    logic can_load;
    logic load;

    sen_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sen_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_pixel (i_pixel),
        .o_stall (o_stall),
        .i_cfg   (cfg),
        .o_valid (grad_valid),
        .o_item  (grad),
        .i_stall (grad_stall)
    );

    sen_nms u_nms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (grad_valid),
        .i_item  (grad),
        .o_stall (grad_stall),
        .i_cfg   (cfg),
        .o_valid (res_valid),
        .o_res   (res),
        .i_stall (!can_load)
    );

    assign take     = r_o_valid && !i_stall;
    assign can_load = !r_o_valid || (take && !r_p_valid);
    assign load     = res_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else if (take && r_p_valid) begin
            r_o_valid <= 1'b1;
            r_p_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= res.emit_up || res.emit_last;
            r_p_valid <= res.emit_up && res.emit_last;
        end else if (take) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_p_valid) begin
            r_o_row  <= r_p_row;
            r_o_col  <= r_p_col;
            r_o_band <= r_p_band;
            r_o_thin <= 1'b0;
            r_o_last <= 1'b1;
        end else if (load) begin
            r_o_col <= res.col;
            if (res.emit_up) begin
                r_o_row  <= res.row_up;
                r_o_band <= res.band_up;
                r_o_thin <= res.thin_up;
                r_o_last <= !res.emit_last;
            end else begin
                r_o_row  <= res.row_last;
                r_o_band <= res.band_last;
                r_o_thin <= 1'b0;
                r_o_last <= 1'b1;
            end
            r_p_row  <= res.row_last;
            r_p_col  <= res.col;
            r_p_band <= res.band_last;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_grid_row    = r_o_row;
    assign o_grid_col    = r_o_col;
    assign o_band_edge   = r_o_band;
    assign o_thin_edge   = r_o_thin;
    assign o_last_of_run = r_o_last;

`ifndef SYNTHESIS
    a_pending_behind_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> r_o_valid)
        else $error("second item held without a first item in the output register");

    a_first_of_pair_has_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_last) |-> r_p_valid)
        else $error("item not marked last but no second item is held");
`endif

endmodule
`default_nettype wire
